@@ rtl/a2r_pkg.sv @@
// a2r_pkg: shared constants for the angles-to-rotation-matrix block
// holds sine pipeline constants, pipeline latency, config register indexes and axis order codes
// no dependencies
`default_nettype none

package a2r_pkg;

  // two pi in unsigned q30
  localparam logic [32:0] TWO_PI_Q30 = 33'h1921FB545;
  localparam int unsigned ONE_Q30_EXP = 30;

  // number of series terms after the first one
  localparam int unsigned TERMS = 7;

  // sine unit latency: input register, four stages per term, output register
  localparam int unsigned SIN_LAT = 2 + 4 * TERMS;

  // product stages after the sine units: pairs, triples, combine
  localparam int unsigned PROD_LAT = 3;

  // configuration register indexes
  localparam logic [1:0] REG_CONVENTION = 2'd0;
  localparam logic [1:0] REG_AXIS_ORDER = 2'd1;

  // convention and axis order, joined as {convention, axis_order}
  localparam logic [3:0] CODE_XZX = 4'd0;
  localparam logic [3:0] CODE_XYX = 4'd1;
  localparam logic [3:0] CODE_YXY = 4'd2;
  localparam logic [3:0] CODE_YZY = 4'd3;
  localparam logic [3:0] CODE_ZYZ = 4'd4;
  localparam logic [3:0] CODE_ZXZ = 4'd5;
  localparam logic [3:0] CODE_XYZ = 4'd8;
  localparam logic [3:0] CODE_YZX = 4'd9;
  localparam logic [3:0] CODE_ZXY = 4'd10;
  localparam logic [3:0] CODE_ZYX = 4'd11;
  localparam logic [3:0] CODE_YXZ = 4'd12;
  localparam logic [3:0] CODE_XZY = 4'd13;

endpackage

`default_nettype wire

@@ rtl/angles_to_rotation_matrix.sv @@
// angles_to_rotation_matrix: three binary angles in, 3x3 rotation matrix out
// top level; uses a2r_pkg and six a2r_sine pipelines
//
// usage
//   slave stream: tdata carries angle_first, angle_second, angle_third, 16 bits
//   each, a full turn being 2^ANGLE_BITS. master stream: tdata carries the nine
//   row-major entries m00..m22 as signed fixed point with FRACTION_BITS fraction
//   bits, 16 bits each, clamped to plus or minus one.
//   config port: index 0 is the convention (0 proper euler, 1 tait-bryan),
//   index 1 the axis order; write only while no transaction is in flight.
//   reserved axis orders give the identity matrix.
// timing
//   an input transaction passes the sine units (four stages per series term)
//   and then the pair, triple and clamped output product stages.
//   one transaction is taken every cycle when the output is not stalled.
// reset and stall
//   reset clears the pipeline valid bits and both config registers.
//   when the receiver holds tready low with a result waiting, the whole
//   pipeline freezes and the input tready drops; nothing is lost or repeated.
`default_nettype none

module angles_to_rotation_matrix
  import a2r_pkg::*;
#(
  parameter int unsigned ANGLE_BITS    = 16,
  parameter int unsigned FRACTION_BITS = 14
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // config write port
  input  wire logic         cfg_we_i,
  input  wire logic [1:0]   cfg_idx_i,
  input  wire logic [2:0]   cfg_data_i,
  // slave stream
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [47:0]  s_axis_tdata,   // angle_first, angle_second, angle_third
  // master stream
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [143:0]      m_axis_tdata    // m00, m01, m02, m10, m11, m12, m20, m21, m22
);

  localparam int unsigned EW  = FRACTION_BITS + 3;
  localparam int unsigned SW  = FRACTION_BITS + 2;
  localparam int unsigned LAT = SIN_LAT + PROD_LAT;
  localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
  localparam logic [2*EW-1:0] HALF_LSB = (2 * EW)'(1) << (FRACTION_BITS - 1);
  localparam logic signed [EW-1:0] ONE = EW'(1) <<< FRACTION_BITS;

  // rounded product, half away from zero
  function automatic logic signed [EW-1:0] mul_rnd(input logic signed [EW-1:0] a,
                                                   input logic signed [EW-1:0] b);
    logic signed [2*EW-1:0] p;
    logic [2*EW-1:0]        m;
    p = a * b;
    m = (p < 0) ? (2 * EW)'(-p) : (2 * EW)'(p);
    m = (m + HALF_LSB) >> FRACTION_BITS;
    return (p < 0) ? -EW'(m) : EW'(m);
  endfunction

  // config registers
  logic       conv_q;
  logic [2:0] order_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conv_q  <= 1'b0;
      order_q <= 3'd0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_CONVENTION) begin
        conv_q <= cfg_data_i[0];
      end else if (cfg_idx_i == REG_AXIS_ORDER) begin
        order_q <= cfg_data_i;
      end
    end
  end

  // pipeline advance and valid bits
  logic           en;
  logic [LAT-1:0] vld_q;

  assign en            = !vld_q[LAT-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
    end
  end

  // angle unpacking and the cosine offset
  logic [ANGLE_BITS+15:0] ax_w, ay_w, az_w;
  logic [ANGLE_BITS-1:0]  ax, ay, az, axc, ayc, azc;

  always_comb begin
    ax_w = (ANGLE_BITS + 16)'(s_axis_tdata[15:0]);
    ay_w = (ANGLE_BITS + 16)'(s_axis_tdata[31:16]);
    az_w = (ANGLE_BITS + 16)'(s_axis_tdata[47:32]);
    ax   = ax_w[ANGLE_BITS-1:0];
    ay   = ay_w[ANGLE_BITS-1:0];
    az   = az_w[ANGLE_BITS-1:0];
    axc  = ax + QUARTER_TURN;
    ayc  = ay + QUARTER_TURN;
    azc  = az + QUARTER_TURN;
  end

  logic signed [SW-1:0] sx_w, cx_w, sy_w, cy_w, sz_w, cz_w;

  a2r_sine #(.ANGLE_BITS(ANGLE_BITS), .FRACTION_BITS(FRACTION_BITS)) u_sx (
    .clk_i(clk_i), .en_i(en), .angle_i(ax),  .sin_o(sx_w));
  a2r_sine #(.ANGLE_BITS(ANGLE_BITS), .FRACTION_BITS(FRACTION_BITS)) u_cx (
    .clk_i(clk_i), .en_i(en), .angle_i(axc), .sin_o(cx_w));
  a2r_sine #(.ANGLE_BITS(ANGLE_BITS), .FRACTION_BITS(FRACTION_BITS)) u_sy (
    .clk_i(clk_i), .en_i(en), .angle_i(ay),  .sin_o(sy_w));
  a2r_sine #(.ANGLE_BITS(ANGLE_BITS), .FRACTION_BITS(FRACTION_BITS)) u_cy (
    .clk_i(clk_i), .en_i(en), .angle_i(ayc), .sin_o(cy_w));
  a2r_sine #(.ANGLE_BITS(ANGLE_BITS), .FRACTION_BITS(FRACTION_BITS)) u_sz (
    .clk_i(clk_i), .en_i(en), .angle_i(az),  .sin_o(sz_w));
  a2r_sine #(.ANGLE_BITS(ANGLE_BITS), .FRACTION_BITS(FRACTION_BITS)) u_cz (
    .clk_i(clk_i), .en_i(en), .angle_i(azc), .sin_o(cz_w));

  logic signed [EW-1:0] sx, cx, sy, cy, sz, cz;

  always_comb begin
    sx = EW'(sx_w);
    cx = EW'(cx_w);
    sy = EW'(sy_w);
    cy = EW'(cy_w);
    sz = EW'(sz_w);
    cz = EW'(cz_w);
  end

  // first product stage: all pair products of two different axes
  logic signed [EW-1:0] f_cxcy_q, f_cxcz_q, f_cxsy_q, f_cxsz_q, f_cycz_q, f_cysx_q;
  logic signed [EW-1:0] f_cysz_q, f_czsx_q, f_czsy_q, f_sxsy_q, f_sxsz_q, f_sysz_q;
  logic signed [EW-1:0] f_sx_q, f_sy_q, f_sz_q, f_cy_q, f_cz_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_cxcy_q <= mul_rnd(cx, cy);
      f_cxcz_q <= mul_rnd(cx, cz);
      f_cxsy_q <= mul_rnd(cx, sy);
      f_cxsz_q <= mul_rnd(cx, sz);
      f_cycz_q <= mul_rnd(cy, cz);
      f_cysx_q <= mul_rnd(cy, sx);
      f_cysz_q <= mul_rnd(cy, sz);
      f_czsx_q <= mul_rnd(cz, sx);
      f_czsy_q <= mul_rnd(cz, sy);
      f_sxsy_q <= mul_rnd(sx, sy);
      f_sxsz_q <= mul_rnd(sx, sz);
      f_sysz_q <= mul_rnd(sy, sz);
      f_sx_q   <= sx;
      f_sy_q   <= sy;
      f_sz_q   <= sz;
      f_cy_q   <= cy;
      f_cz_q   <= cz;
    end
  end

  // second product stage: triple products from a rounded pair
  logic signed [EW-1:0] cxcy_q, cxcz_q, cxsy_q, cxsz_q, cycz_q, cysx_q;
  logic signed [EW-1:0] cysz_q, czsx_q, czsy_q, sxsy_q, sxsz_q, sysz_q;
  logic signed [EW-1:0] cxcycz_q, cxcysz_q, cysxsz_q, cyczsx_q;
  logic signed [EW-1:0] cxsysz_q, cxczsy_q, sxsysz_q, czsxsy_q;
  logic signed [EW-1:0] sx_q, sy_q, sz_q, cy_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      cxcycz_q <= mul_rnd(f_cxcy_q, f_cz_q);
      cxcysz_q <= mul_rnd(f_cxcy_q, f_sz_q);
      cysxsz_q <= mul_rnd(f_cysx_q, f_sz_q);
      cyczsx_q <= mul_rnd(f_cycz_q, f_sx_q);
      cxsysz_q <= mul_rnd(f_cxsy_q, f_sz_q);
      cxczsy_q <= mul_rnd(f_cxcz_q, f_sy_q);
      sxsysz_q <= mul_rnd(f_sxsy_q, f_sz_q);
      czsxsy_q <= mul_rnd(f_czsx_q, f_sy_q);
      cxcy_q   <= f_cxcy_q;
      cxcz_q   <= f_cxcz_q;
      cxsy_q   <= f_cxsy_q;
      cxsz_q   <= f_cxsz_q;
      cycz_q   <= f_cycz_q;
      cysx_q   <= f_cysx_q;
      cysz_q   <= f_cysz_q;
      czsx_q   <= f_czsx_q;
      czsy_q   <= f_czsy_q;
      sxsy_q   <= f_sxsy_q;
      sxsz_q   <= f_sxsz_q;
      sysz_q   <= f_sysz_q;
      sx_q     <= f_sx_q;
      sy_q     <= f_sy_q;
      sz_q     <= f_sz_q;
      cy_q     <= f_cy_q;
    end
  end

  // entry formulas per convention and axis order
  logic signed [EW-1:0] e [0:8];

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      e[i] = (i % 4 == 0) ? ONE : '0;
    end
    case ({conv_q, order_q})
      CODE_XZX: begin
        e[0] = cy_q; e[1] = -czsy_q; e[2] = sysz_q;
        e[3] = cxsy_q; e[4] = cxcycz_q - sxsz_q; e[5] = -czsx_q - cxcysz_q;
        e[6] = sxsy_q; e[7] = cxsz_q + cyczsx_q; e[8] = cxcz_q - cysxsz_q;
      end
      CODE_XYX: begin
        e[0] = cy_q; e[1] = sysz_q; e[2] = czsy_q;
        e[3] = sxsy_q; e[4] = cxcz_q - cysxsz_q; e[5] = -cxsz_q - cyczsx_q;
        e[6] = -cxsy_q; e[7] = czsx_q + cxcysz_q; e[8] = cxcycz_q - sxsz_q;
      end
      CODE_YXY: begin
        e[0] = cxcz_q - cysxsz_q; e[1] = sxsy_q; e[2] = cxsz_q + cyczsx_q;
        e[3] = sysz_q; e[4] = cy_q; e[5] = -czsy_q;
        e[6] = -czsx_q - cxcysz_q; e[7] = cxsy_q; e[8] = cxcycz_q - sxsz_q;
      end
      CODE_YZY: begin
        e[0] = cxcycz_q - sxsz_q; e[1] = -cxsy_q; e[2] = czsx_q + cxcysz_q;
        e[3] = czsy_q; e[4] = cy_q; e[5] = sysz_q;
        e[6] = -cxsz_q - cyczsx_q; e[7] = sxsy_q; e[8] = cxcz_q - cysxsz_q;
      end
      CODE_ZYZ: begin
        e[0] = cxcycz_q - sxsz_q; e[1] = -czsx_q - cxcysz_q; e[2] = cxsy_q;
        e[3] = cxsz_q + cyczsx_q; e[4] = cxcz_q - cysxsz_q; e[5] = sxsy_q;
        e[6] = -czsy_q; e[7] = sysz_q; e[8] = cy_q;
      end
      CODE_ZXZ: begin
        e[0] = cxcz_q - cysxsz_q; e[1] = -cxsz_q - cyczsx_q; e[2] = sxsy_q;
        e[3] = czsx_q + cxcysz_q; e[4] = cxcycz_q - sxsz_q; e[5] = -cxsy_q;
        e[6] = sysz_q; e[7] = czsy_q; e[8] = cy_q;
      end
      CODE_XYZ: begin
        e[0] = cxcy_q; e[1] = cxsysz_q - czsx_q; e[2] = sxsz_q + cxczsy_q;
        e[3] = cysx_q; e[4] = cxcz_q + sxsysz_q; e[5] = czsxsy_q - cxsz_q;
        e[6] = -sy_q; e[7] = cysz_q; e[8] = cycz_q;
      end
      CODE_YZX: begin
        e[0] = cycz_q; e[1] = sxsy_q - cxcysz_q; e[2] = cxsy_q + cysxsz_q;
        e[3] = sz_q; e[4] = cxcz_q; e[5] = -czsx_q;
        e[6] = -czsy_q; e[7] = cysx_q + cxsysz_q; e[8] = cxcy_q - sxsysz_q;
      end
      CODE_ZXY: begin
        e[0] = cycz_q - sxsysz_q; e[1] = -cxsz_q; e[2] = czsy_q + cysxsz_q;
        e[3] = czsxsy_q + cysz_q; e[4] = cxcz_q; e[5] = sysz_q - cyczsx_q;
        e[6] = -cxsy_q; e[7] = sx_q; e[8] = cxcy_q;
      end
      CODE_ZYX: begin
        e[0] = cycz_q; e[1] = czsxsy_q - cxsz_q; e[2] = cxczsy_q + sxsz_q;
        e[3] = cysz_q; e[4] = cxcz_q + sxsysz_q; e[5] = cxsysz_q - czsx_q;
        e[6] = -sy_q; e[7] = cysx_q; e[8] = cxcy_q;
      end
      CODE_YXZ: begin
        e[0] = cycz_q + sxsysz_q; e[1] = czsxsy_q - cysz_q; e[2] = cxsy_q;
        e[3] = cxsz_q; e[4] = cxcz_q; e[5] = -sx_q;
        e[6] = cysxsz_q - czsy_q; e[7] = cyczsx_q + sysz_q; e[8] = cxcy_q;
      end
      CODE_XZY: begin
        e[0] = cycz_q; e[1] = -sz_q; e[2] = czsy_q;
        e[3] = sxsy_q + cxcysz_q; e[4] = cxcz_q; e[5] = cxsysz_q - cysx_q;
        e[6] = cysxsz_q - cxsy_q; e[7] = czsx_q; e[8] = cxcy_q + sxsysz_q;
      end
      default: begin
      end
    endcase
  end

  // clamp and output register
  logic signed [EW-1:0] out_q [0:8];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        if (e[i] > ONE) begin
          out_q[i] <= ONE;
        end else if (e[i] < -ONE) begin
          out_q[i] <= -ONE;
        end else begin
          out_q[i] <= e[i];
        end
      end
    end
  end

  // output packing to 16-bit fields
  logic signed [63:0] wide [0:8];
  logic               range_ok;

  always_comb begin
    range_ok = 1'b1;
    for (int i = 0; i < 9; i++) begin
      wide[i] = 64'(out_q[i]);
      m_axis_tdata[16*i +: 16] = wide[i][15:0];
      if (out_q[i] > ONE || out_q[i] < -ONE) begin
        range_ok = 1'b0;
      end
    end
  end

  // checks
  a_cfg_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && cfg_idx_i == REG_AXIS_ORDER |=> order_q == $past(cfg_data_i))
    else $error("axis order write lost");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> vld_q[0])
    else $error("accepted transaction not in pipeline");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> range_ok)
    else $error("matrix entry outside plus or minus one");

  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(vld_q))
    else $error("pipeline moved during output stall");

endmodule

`default_nettype wire

@@ rtl/a2r_sine.sv @@
// a2r_sine: pipelined fixed-point sine of a binary angle
// quadrant fold, radian conversion, series terms one per four stages; uses a2r_pkg
`default_nettype none

module a2r_sine
  import a2r_pkg::*;
#(
  parameter int unsigned ANGLE_BITS    = 16,
  parameter int unsigned FRACTION_BITS = 14
) (
  input  wire logic                            clk_i,
  input  wire logic                            en_i,
  input  wire logic [ANGLE_BITS-1:0]           angle_i,
  output logic signed [FRACTION_BITS+1:0]      sin_o
);

  localparam int unsigned RW = ANGLE_BITS - 1;
  localparam logic [RW-1:0] QUARTER = RW'(1) << (ANGLE_BITS - 2);
  localparam logic [63:0] HALF_TURN = 64'd1 << (ANGLE_BITS - 1);
  localparam int unsigned SH = ONE_Q30_EXP - FRACTION_BITS;
  localparam logic [32:0] RND = (SH > 0) ? (33'd1 << (SH - 1)) : 33'd0;
  localparam logic signed [32:0] ONE_S = 33'sd1 <<< ONE_Q30_EXP;

  logic [30:0]        x_q   [0:TERMS];
  logic [30:0]        t_q   [0:TERMS];
  logic signed [32:0] s_q   [0:TERMS];
  logic [1:0]         qd_q  [0:TERMS];

  // quadrant fold and conversion to radians in q30
  logic [1:0]    quad;
  logic [RW-1:0] r;
  logic [63:0]   xw;

  always_comb begin
    quad = angle_i[ANGLE_BITS-1:ANGLE_BITS-2];
    r    = {1'b0, angle_i[ANGLE_BITS-3:0]};
    if (quad[0]) begin
      r = QUARTER - r;
    end
    xw = ((64'(r) * 64'(TWO_PI_Q30)) + HALF_TURN) >> ANGLE_BITS;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]  <= xw[30:0];
      t_q[0]  <= xw[30:0];
      s_q[0]  <= 33'(signed'({2'b00, xw[30:0]}));
      qd_q[0] <= quad;
    end
  end

  // one series term: two q30 multiplies, reciprocal divide, correction and sum
  // the intermediate power of x can reach just under 2^32 in the first term
  for (genvar k = 1; k <= TERMS; k++) begin : g_term
    localparam logic [39:0] DIV = 40'((2 * k) * (2 * k + 1));
    localparam logic [63:0] RECIP = (64'd1 << 32) / 64'((2 * k) * (2 * k + 1));

    logic [31:0]        a_t_q, b_t_q, c_t_q;
    logic [30:0]        a_x_q, b_x_q, c_x_q, c_q0_q;
    logic signed [32:0] a_s_q, b_s_q, c_s_q;
    logic [1:0]         a_qd_q, b_qd_q, c_qd_q;
    logic [63:0]        a_p, b_p, c_p;
    logic [39:0]        rem;
    logic [30:0]        quo;

    always_comb begin
      a_p = (64'(t_q[k-1]) * 64'(x_q[k-1])) >> ONE_Q30_EXP;
      b_p = (64'(a_t_q) * 64'(a_x_q)) >> ONE_Q30_EXP;
      c_p = (64'(b_t_q) * RECIP) >> 32;
      rem = 40'(c_t_q) - (40'(c_q0_q) * DIV);
      quo = c_q0_q + ((rem >= DIV) ? 31'd1 : 31'd0);
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        a_t_q  <= a_p[31:0];
        a_x_q  <= x_q[k-1];
        a_s_q  <= s_q[k-1];
        a_qd_q <= qd_q[k-1];
        b_t_q  <= b_p[31:0];
        b_x_q  <= a_x_q;
        b_s_q  <= a_s_q;
        b_qd_q <= a_qd_q;
        c_q0_q <= c_p[30:0];
        c_t_q  <= b_t_q;
        c_x_q  <= b_x_q;
        c_s_q  <= b_s_q;
        c_qd_q <= b_qd_q;
        t_q[k]  <= quo;
        x_q[k]  <= c_x_q;
        qd_q[k] <= c_qd_q;
        if (k % 2 == 1) begin
          s_q[k] <= c_s_q - 33'(signed'({2'b00, quo}));
        end else begin
          s_q[k] <= c_s_q + 33'(signed'({2'b00, quo}));
        end
      end
    end
  end

  // clamp to [0, 1], round to output precision and unfold the sign
  logic signed [32:0]       s_cl;
  logic [32:0]              s_rd;
  logic [FRACTION_BITS+1:0] v;

  always_comb begin
    s_cl = s_q[TERMS];
    if (s_cl < 0) begin
      s_cl = '0;
    end
    if (s_cl > ONE_S) begin
      s_cl = ONE_S;
    end
    s_rd = (33'(s_cl) + RND) >> SH;
    v    = s_rd[FRACTION_BITS+1:0];
    if (qd_q[TERMS][1]) begin
      v = -v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_o <= signed'(v);
    end
  end

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// tb: self-checking bench for angles_to_rotation_matrix
// predicts each rotation matrix from the angles and the two config registers
// depends on a2r_pkg and the angles_to_rotation_matrix rtl
`default_nettype none

// expected matrices, oldest first
class matrix_scoreboard;
  logic [143:0] pending_q[$];
  int           fail_cnt;
  bit           conv;
  logic [2:0]   order;

  function new();
    fail_cnt = 0;
    conv     = 1'b0;
    order    = 3'd0;
  endfunction

  // sine of a binary angle, q30 series rounded to q2.14
  function longint sine_fx(input logic [15:0] a);
    logic [1:0]  quad;
    longint unsigned r, x, t;
    longint      acc, v;
    quad = a[15:14];
    r    = a[13:0];
    if (quad[0]) begin
      r = 64'd16384 - r;
    end
    x   = (r * 64'h1921FB545 + 64'd32768) >> 16;
    t   = x;
    acc = x;
    for (int k = 1; k <= 7; k++) begin
      t = (t * x) >> 30;
      t = (t * x) >> 30;
      t = t / ((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        acc = acc - longint'(t);
      end else begin
        acc = acc + longint'(t);
      end
    end
    if (acc < 0) acc = 0;
    if (acc > (64'sd1 << 30)) acc = 64'sd1 << 30;
    v = (acc + (1 << 15)) >>> 16;
    return quad[1] ? -v : v;
  endfunction

  // two-factor product rounded half away from zero
  function longint mul2(input longint a, input longint b);
    longint p, m;
    p = a * b;
    m = (p < 0) ? -p : p;
    m = (m + 8192) >>> 14;
    return (p < 0) ? -m : m;
  endfunction

  function longint mul3(input longint a, input longint b, input longint c);
    return mul2(mul2(a, b), c);
  endfunction

  // note an accepted angle triple
  function void note_angles(input logic [47:0] ang);
    longint sx, cx, sy, cy, sz, cz, v;
    longint e[9];
    logic [143:0] packed_m;
    sx = sine_fx(ang[15:0]);  cx = sine_fx(ang[15:0] + 16'h4000);
    sy = sine_fx(ang[31:16]); cy = sine_fx(ang[31:16] + 16'h4000);
    sz = sine_fx(ang[47:32]); cz = sine_fx(ang[47:32] + 16'h4000);
    for (int i = 0; i < 9; i++) e[i] = (i % 4 == 0) ? 16384 : 0;
    case ({conv, order})
      a2r_pkg::CODE_XZX: begin
        e[0] = cy; e[1] = -mul2(cz, sy); e[2] = mul2(sy, sz);
        e[3] = mul2(cx, sy); e[4] = mul3(cx, cy, cz) - mul2(sx, sz);
        e[5] = -mul2(cz, sx) - mul3(cx, cy, sz);
        e[6] = mul2(sx, sy); e[7] = mul2(cx, sz) + mul3(cy, cz, sx);
        e[8] = mul2(cx, cz) - mul3(cy, sx, sz);
      end
      a2r_pkg::CODE_XYX: begin
        e[0] = cy; e[1] = mul2(sy, sz); e[2] = mul2(cz, sy);
        e[3] = mul2(sx, sy); e[4] = mul2(cx, cz) - mul3(cy, sx, sz);
        e[5] = -mul2(cx, sz) - mul3(cy, cz, sx);
        e[6] = -mul2(cx, sy); e[7] = mul2(cz, sx) + mul3(cx, cy, sz);
        e[8] = mul3(cx, cy, cz) - mul2(sx, sz);
      end
      a2r_pkg::CODE_YXY: begin
        e[0] = mul2(cx, cz) - mul3(cy, sx, sz); e[1] = mul2(sx, sy);
        e[2] = mul2(cx, sz) + mul3(cy, cz, sx);
        e[3] = mul2(sy, sz); e[4] = cy; e[5] = -mul2(cz, sy);
        e[6] = -mul2(cz, sx) - mul3(cx, cy, sz); e[7] = mul2(cx, sy);
        e[8] = mul3(cx, cy, cz) - mul2(sx, sz);
      end
      a2r_pkg::CODE_YZY: begin
        e[0] = mul3(cx, cy, cz) - mul2(sx, sz); e[1] = -mul2(cx, sy);
        e[2] = mul2(cz, sx) + mul3(cx, cy, sz);
        e[3] = mul2(cz, sy); e[4] = cy; e[5] = mul2(sy, sz);
        e[6] = -mul2(cx, sz) - mul3(cy, cz, sx); e[7] = mul2(sx, sy);
        e[8] = mul2(cx, cz) - mul3(cy, sx, sz);
      end
      a2r_pkg::CODE_ZYZ: begin
        e[0] = mul3(cx, cy, cz) - mul2(sx, sz);
        e[1] = -mul2(cz, sx) - mul3(cx, cy, sz); e[2] = mul2(cx, sy);
        e[3] = mul2(cx, sz) + mul3(cy, cz, sx);
        e[4] = mul2(cx, cz) - mul3(cy, sx, sz); e[5] = mul2(sx, sy);
        e[6] = -mul2(cz, sy); e[7] = mul2(sy, sz); e[8] = cy;
      end
      a2r_pkg::CODE_ZXZ: begin
        e[0] = mul2(cx, cz) - mul3(cy, sx, sz);
        e[1] = -mul2(cx, sz) - mul3(cy, cz, sx); e[2] = mul2(sx, sy);
        e[3] = mul2(cz, sx) + mul3(cx, cy, sz);
        e[4] = mul3(cx, cy, cz) - mul2(sx, sz); e[5] = -mul2(cx, sy);
        e[6] = mul2(sy, sz); e[7] = mul2(cz, sy); e[8] = cy;
      end
      a2r_pkg::CODE_XYZ: begin
        e[0] = mul2(cx, cy); e[1] = mul3(cx, sy, sz) - mul2(cz, sx);
        e[2] = mul2(sx, sz) + mul3(cx, cz, sy);
        e[3] = mul2(cy, sx); e[4] = mul2(cx, cz) + mul3(sx, sy, sz);
        e[5] = mul3(cz, sx, sy) - mul2(cx, sz);
        e[6] = -sy; e[7] = mul2(cy, sz); e[8] = mul2(cy, cz);
      end
      a2r_pkg::CODE_YZX: begin
        e[0] = mul2(cy, cz); e[1] = mul2(sx, sy) - mul3(cx, cy, sz);
        e[2] = mul2(cx, sy) + mul3(cy, sx, sz);
        e[3] = sz; e[4] = mul2(cx, cz); e[5] = -mul2(cz, sx);
        e[6] = -mul2(cz, sy); e[7] = mul2(cy, sx) + mul3(cx, sy, sz);
        e[8] = mul2(cx, cy) - mul3(sx, sy, sz);
      end
      a2r_pkg::CODE_ZXY: begin
        e[0] = mul2(cy, cz) - mul3(sx, sy, sz); e[1] = -mul2(cx, sz);
        e[2] = mul2(cz, sy) + mul3(cy, sx, sz);
        e[3] = mul3(cz, sx, sy) + mul2(cy, sz); e[4] = mul2(cx, cz);
        e[5] = mul2(sy, sz) - mul3(cy, cz, sx);
        e[6] = -mul2(cx, sy); e[7] = sx; e[8] = mul2(cx, cy);
      end
      a2r_pkg::CODE_ZYX: begin
        e[0] = mul2(cy, cz); e[1] = mul3(cz, sx, sy) - mul2(cx, sz);
        e[2] = mul3(cx, cz, sy) + mul2(sx, sz);
        e[3] = mul2(cy, sz); e[4] = mul2(cx, cz) + mul3(sx, sy, sz);
        e[5] = mul3(cx, sy, sz) - mul2(cz, sx);
        e[6] = -sy; e[7] = mul2(cy, sx); e[8] = mul2(cx, cy);
      end
      a2r_pkg::CODE_YXZ: begin
        e[0] = mul2(cy, cz) + mul3(sx, sy, sz);
        e[1] = mul3(cz, sx, sy) - mul2(cy, sz); e[2] = mul2(cx, sy);
        e[3] = mul2(cx, sz); e[4] = mul2(cx, cz); e[5] = -sx;
        e[6] = mul3(cy, sx, sz) - mul2(cz, sy);
        e[7] = mul3(cy, cz, sx) + mul2(sy, sz); e[8] = mul2(cx, cy);
      end
      a2r_pkg::CODE_XZY: begin
        e[0] = mul2(cy, cz); e[1] = -sz; e[2] = mul2(cz, sy);
        e[3] = mul2(sx, sy) + mul3(cx, cy, sz); e[4] = mul2(cx, cz);
        e[5] = mul3(cx, sy, sz) - mul2(cy, sx);
        e[6] = mul3(cy, sx, sz) - mul2(cx, sy); e[7] = mul2(cz, sx);
        e[8] = mul2(cx, cy) + mul3(sx, sy, sz);
      end
      default: begin
      end
    endcase
    // clamp each entry to plus or minus one
    for (int i = 0; i < 9; i++) begin
      v = e[i];
      if (v > 16384) v = 16384;
      if (v < -16384) v = -16384;
      packed_m[16 * i +: 16] = v[15:0];
    end
    pending_q.push_back(packed_m);
  endfunction

  // compare a result transaction with the oldest expectation
  function void check_matrix(input logic [143:0] got);
    logic [143:0] want;
    string        names[9];
    names = '{"m00", "m01", "m02", "m10", "m11", "m12", "m20", "m21", "m22"};
    if (pending_q.size() == 0) begin
      $error("unexpected result transaction %h", got);
      fail_cnt++;
      return;
    end
    want = pending_q.pop_front();
    for (int i = 0; i < 9; i++) begin
      if (got[16 * i +: 16] !== want[16 * i +: 16]) begin
        $error("%s expected %0d got %0d", names[i],
               $signed(want[16 * i +: 16]), $signed(got[16 * i +: 16]));
        fail_cnt++;
      end
    end
  endfunction
endclass

module tb;
  import a2r_pkg::*;

  localparam int LATENCY = SIN_LAT + PROD_LAT;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_idx_i = '0;
  logic [2:0]   cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [47:0]  s_axis_tdata = '0;   // angle_first, angle_second, angle_third
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [143:0] m_axis_tdata;        // m00, m01, m02, m10, m11, m12, m20, m21, m22

  matrix_scoreboard board = new();
  bit hold_sink = 1'b0;
  bit in_done = 1'b0;

  angles_to_rotation_matrix uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // gap length: mostly short, now and then long
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // config write, only while the block is idle
  task automatic write_reg(input logic [1:0] idx, input logic [2:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == REG_CONVENTION) board.conv = val[0];
    else if (idx == REG_AXIS_ORDER) board.order = val;
  endtask

  // one input transaction with an optional gap before it
  task automatic send_angles(input logic [47:0] ang, input bit with_gap);
    int g;
    g = with_gap ? gap_len() : 0;
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ang;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_angles(ang);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_angle();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return 16'(16'h4000 * $urandom_range(0, 3));
    if (p == 1) return 16'(16'h4000 * $urandom_range(0, 3) + $urandom_range(0, 1) - 1);
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  // stimulus
  initial begin
    logic [15:0] corner[8];
    corner = '{16'h0000, 16'hFFFF, 16'h4000, 16'h8000, 16'hC000, 16'h3FFF,
               16'h2000, 16'h1234};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes and quadrant boundaries at reset settings
    for (int i = 0; i < 8; i++) begin
      send_angles({corner[(i + 3) % 8], corner[(i + 5) % 8], corner[i]}, 1'b0);
    end
    send_angles(48'hFFFF_FFFF_FFFF, 1'b0);
    send_angles(48'h0, 1'b1);
    drain();
    // every axis order of both conventions, reserved ones too
    for (int c = 0; c < 2; c++) begin
      write_reg(REG_CONVENTION, 3'(c == 0 ? 6 : 7));
      for (int o = 0; o < 8; o++) begin
        write_reg(REG_AXIS_ORDER, 3'(o));
        send_angles({corner[(o + 1) % 8], corner[(o + 6) % 8], corner[o]}, 1'b0);
        drain();
      end
    end

    // random phases, each with its own setting; the long hold-off phase sends
    // back to back and more than the pipeline holds so that the input stalls
    for (int ph = 0; ph < 15; ph++) begin
      write_reg(REG_CONVENTION, 3'($urandom_range(0, 7)));
      write_reg(REG_AXIS_ORDER, 3'(ph < 12 ? ph % 6 : $urandom_range(6, 7)));
      if (ph == 4) hold_sink = 1'b1;
      for (int n = 0; n < (ph == 4 ? 44 : 28); n++) begin
        send_angles({rand_angle(), rand_angle(), rand_angle()}, ph % 3 != 0 && ph != 4);
      end
      hold_sink = 1'b0;
      drain();
    end
    in_done = 1'b1;
  end

  // result side: random back-pressure plus one long hold-off
  initial begin
    int g;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) board.check_matrix(m_axis_tdata);
      if (hold_sink) begin
        m_axis_tready <= 1'b0;
        repeat (80) @(posedge clk_i);
        hold_sink = 1'b0;
        m_axis_tready <= 1'b1;
      end else begin
        g = gap_len();
        m_axis_tready <= (g == 0) || ($urandom_range(0, 3) == 0);
      end
    end
  end

  // end of run
  initial begin
    wait (in_done);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (board.fail_cnt == 0 && board.pending_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (board.pending_q.size() != 0) $error("%0d results missing", board.pending_q.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("*** FAILED ***");
    $finish;
  end
endmodule

`default_nettype wire
